>>> rtl/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

    // Unit axis component, signed Q2.30.
    typedef logic signed [31:0] axis_t;

    localparam int AXIS_W = 32;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

endpackage

>>> rtl/lav_unit3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unit3
// Pipelined 3-vector normalizer: aligns the magnitudes, takes the floor
// square root of the sum of squares and divides each component by it.
// ----------------------------------------------------------------------------
module lav_unit3
    import lav_pkg::*;
#(
    parameter int W  = 64,
    parameter int SW = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [W-1:0] in_vec [3],
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic                out_ok,
    output axis_t               out_q [3],
    output logic [SW-1:0]       out_side
);

    localparam int NORM_ST = 3;
    localparam int SQ_ST   = 32;
    localparam int DIV_ST  = 30;

    typedef struct packed {
        logic [2:0]    neg;
        logic          ok;
        logic [SW-1:0] side;
    } tag_t;

    // Magnitude and alignment stages.
    logic [W-1:0]      mag_w [3];
    logic [2:0][63:0]  al_reg  [0:NORM_ST];
    logic [63:0]       or_reg  [0:NORM_ST];
    tag_t              tal_reg [0:NORM_ST];
    logic              val_reg [0:NORM_ST];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_w[i] = in_vec[i][W-1] ? W'(-in_vec[i]) : W'(in_vec[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg[0] <= 1'b0;
        end
        else
        begin
            val_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            al_reg[0][i]       <= 64'(mag_w[i]);
            tal_reg[0].neg[i]  <= in_vec[i][W-1];
        end
        or_reg[0]        <= 64'(mag_w[0]) | 64'(mag_w[1]) | 64'(mag_w[2]);
        tal_reg[0].ok    <= (mag_w[0] != '0) || (mag_w[1] != '0) || (mag_w[2] != '0);
        tal_reg[0].side  <= in_side;
    end

    // Each stage shifts left by two binary steps while the top bits are clear.
    for (genvar j = 1; j <= NORM_ST; j++)
    begin : g_align
        localparam int S1 = 32 >> (2 * (j - 1));
        localparam int S2 = S1 / 2;
        logic [2:0][63:0] x1, x2;
        logic [63:0]      o1, o2;

        always_comb
        begin
            if (or_reg[j-1][63 -: S1] == '0)
            begin
                o1 = or_reg[j-1] << S1;
                for (int i = 0; i < 3; i++) x1[i] = al_reg[j-1][i] << S1;
            end
            else
            begin
                o1 = or_reg[j-1];
                x1 = al_reg[j-1];
            end
            if (o1[63 -: S2] == '0)
            begin
                o2 = o1 << S2;
                for (int i = 0; i < 3; i++) x2[i] = x1[i] << S2;
            end
            else
            begin
                o2 = o1;
                x2 = x1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[j] <= 1'b0;
            end
            else
            begin
                val_reg[j] <= val_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            al_reg[j]  <= x2;
            or_reg[j]  <= o2;
            tal_reg[j] <= tal_reg[j-1];
        end
    end

    // Squares of the aligned components; the largest lies in [2^29, 2^30).
    logic [2:0][29:0] bq_reg;
    logic [59:0]      sqr_reg [3];
    tag_t             tq_reg;
    logic             vq_reg;
    logic [61:0]      sum_reg;
    logic [2:0][29:0] bs_reg;
    tag_t             ts_reg;
    logic             vs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else
        begin
            vq_reg <= val_reg[NORM_ST];
            vs_reg <= vq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            bq_reg[i]  <= al_reg[NORM_ST][i][63:34];
            sqr_reg[i] <= 60'(al_reg[NORM_ST][i][63:34]) * 60'(al_reg[NORM_ST][i][63:34]);
        end
        tq_reg  <= tal_reg[NORM_ST];
        sum_reg <= 62'(sqr_reg[0]) + 62'(sqr_reg[1]) + 62'(sqr_reg[2]);
        bs_reg  <= bq_reg;
        ts_reg  <= tq_reg;
    end

    // Digit-by-digit floor square root, one result bit per stage.
    logic [63:0]      sn_reg  [0:SQ_ST];
    logic [63:0]      sr_reg  [0:SQ_ST];
    logic [2:0][29:0] sb_reg  [0:SQ_ST];
    tag_t             stg_reg [0:SQ_ST];
    logic             sv_reg  [0:SQ_ST];

    always_comb
    begin
        sn_reg[0]  = 64'(sum_reg);
        sr_reg[0]  = '0;
        sb_reg[0]  = bs_reg;
        stg_reg[0] = ts_reg;
        sv_reg[0]  = vs_reg;
    end

    for (genvar k = 1; k <= SQ_ST; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_ST - k));
        logic [63:0] trial;

        assign trial = sr_reg[k-1] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (sn_reg[k-1] >= trial)
            begin
                sn_reg[k] <= sn_reg[k-1] - trial;
                sr_reg[k] <= (sr_reg[k-1] >> 1) + BIT;
            end
            else
            begin
                sn_reg[k] <= sn_reg[k-1];
                sr_reg[k] <= sr_reg[k-1] >> 1;
            end
            sb_reg[k]  <= sb_reg[k-1];
            stg_reg[k] <= stg_reg[k-1];
        end
    end

    // Restoring division of (b << 30) by the length, three lanes in step.
    logic [30:0]      dlen_reg [0:DIV_ST];
    logic [2:0][30:0] drem_reg [0:DIV_ST];
    logic [2:0][30:0] dq_reg   [0:DIV_ST];
    tag_t             dtg_reg  [0:DIV_ST];
    logic             dv_reg   [0:DIV_ST];
    logic [30:0]      len_w;

    assign len_w = sr_reg[SQ_ST][30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= sv_reg[SQ_ST];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (31'(sb_reg[SQ_ST][i]) >= len_w)
            begin
                drem_reg[0][i] <= 31'(sb_reg[SQ_ST][i]) - len_w;
                dq_reg[0][i]   <= 31'd1;
            end
            else
            begin
                drem_reg[0][i] <= 31'(sb_reg[SQ_ST][i]);
                dq_reg[0][i]   <= '0;
            end
        end
        dlen_reg[0] <= len_w;
        dtg_reg[0]  <= stg_reg[SQ_ST];
    end

    for (genvar k = 1; k <= DIV_ST; k++)
    begin : g_div
        logic [2:0][31:0] r2;
        logic [2:0]       ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r2[i] = {drem_reg[k-1][i], 1'b0};
                ge[i] = r2[i] >= {1'b0, dlen_reg[k-1]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[k][i] <= ge[i] ? 31'(r2[i] - {1'b0, dlen_reg[k-1]}) : r2[i][30:0];
                dq_reg[k][i]   <= {dq_reg[k-1][i][29:0], ge[i]};
            end
            dlen_reg[k] <= dlen_reg[k-1];
            dtg_reg[k]  <= dtg_reg[k-1];
        end
    end

    // Apply the signs and register the result.
    axis_t         q_reg [3];
    logic          ok_reg;
    logic [SW-1:0] side_reg;
    logic          ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= dv_reg[DIV_ST];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= dtg_reg[DIV_ST].neg[i] ? -axis_t'({1'b0, dq_reg[DIV_ST][i]})
                                               :  axis_t'({1'b0, dq_reg[DIV_ST][i]});
        end
        ok_reg   <= dtg_reg[DIV_ST].ok;
        side_reg <= dtg_reg[DIV_ST].side;
    end

    assign out_valid = ov_reg;
    assign out_ok    = ok_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/look_at_view_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix builder in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload
//  -------   ----------------   ------------------------------------------
//  camera    start / busy       eye_*, target_*, up_* (signed Q16.16)
//  rows      row_valid strobe   row_index, col_a..col_c (Q2.30),
//                               translation (Q16.16), last_row, degenerate
//
// A transaction is accepted when start is high and busy is low. Every
// camera yields four row transactions on consecutive cycles, so busy stays
// high after an accept until the row output can take another camera, a pace
// set by the single row output. The datapath is a fixed-latency pipeline of
// well over a hundred stages, dominated by the two square root pipelines
// (32 stages each) and the two divider pipelines (31 stages each).
// Reset clears the valid bits, the busy counter and the row sequencer.
// The receiver cannot stall, so nothing in the pipeline ever waits.
//
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               row_valid,
    output logic [1:0]         row_index,
    output logic signed [31:0] col_a,
    output logic signed [31:0] col_b,
    output logic signed [31:0] col_c,
    output logic signed [31:0] translation,
    output logic               last_row,
    output logic               degenerate
);

    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_Z = 2'd2;
    localparam logic [1:0] ROW_W = 2'd3;

    localparam int SIDE1_W = 6 * AXIS_W;
    localparam int SIDE2_W = 6 * AXIS_W + 1;

    localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;
    localparam logic signed [65:0] POS_Q30  = 66'sd1073741824;
    localparam logic signed [65:0] NEG_Q30  = -66'sd1073741824;
    localparam logic signed [65:0] POS_SAT  = 66'sd2147483647;
    localparam logic signed [65:0] NEG_SAT  = -66'sd2147483648;

    // Round to nearest (ties up) when dropping 30 fraction bits.
    function automatic logic signed [65:0] rnd_q30(input logic signed [65:0] v);
        logic signed [65:0] s;
        s = v + HALF_Q30;
        return s >>> 30;
    endfunction

    // ------------------------------------------------------------------
    // Accept and issue pacing.
    // ------------------------------------------------------------------
    logic       accept;
    logic [1:0] busy_cnt_reg;

    assign accept = start && !busy;
    assign busy   = busy_cnt_reg != 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            busy_cnt_reg <= 2'd3;
        end
        else if (busy)
        begin
            busy_cnt_reg <= busy_cnt_reg - 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the camera and form the view direction eye - target.
    // ------------------------------------------------------------------
    logic signed [31:0] eye0_reg [3];
    logic signed [31:0] up0_reg  [3];
    logic signed [32:0] d0_reg   [3];
    logic               v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        eye0_reg[0] <= eye_x;
        eye0_reg[1] <= eye_y;
        eye0_reg[2] <= eye_z;
        up0_reg[0]  <= up_x;
        up0_reg[1]  <= up_y;
        up0_reg[2]  <= up_z;
        d0_reg[0]   <= 33'(eye_x) - 33'(target_x);
        d0_reg[1]   <= 33'(eye_y) - 33'(target_y);
        d0_reg[2]   <= 33'(eye_z) - 33'(target_z);
    end

    // ------------------------------------------------------------------
    // Z axis: normalize the view direction. Eye and up ride along.
    // ------------------------------------------------------------------
    logic [SIDE1_W-1:0] side1_in, side1_out;
    axis_t              z1 [3];
    logic               zok1, v1;
    logic signed [31:0] eye1 [3];
    logic signed [31:0] up1  [3];

    assign side1_in = {eye0_reg[0], eye0_reg[1], eye0_reg[2],
                       up0_reg[0], up0_reg[1], up0_reg[2]};

    lav_unit3 #(.W(33), .SW(SIDE1_W)) u_norm_z
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_vec    (d0_reg),
        .in_side   (side1_in),
        .out_valid (v1),
        .out_ok    (zok1),
        .out_q     (z1),
        .out_side  (side1_out)
    );

    assign eye1[0] = side1_out[191:160];
    assign eye1[1] = side1_out[159:128];
    assign eye1[2] = side1_out[127:96];
    assign up1[0]  = side1_out[95:64];
    assign up1[1]  = side1_out[63:32];
    assign up1[2]  = side1_out[31:0];

    // ------------------------------------------------------------------
    // Stages 2 and 3: up cross z, products first and then differences.
    // ------------------------------------------------------------------
    logic signed [63:0] cp2_reg [6];
    axis_t              eye2_reg [3];
    axis_t              z2_reg [3];
    logic               zok2_reg, v2_reg;
    logic signed [63:0] c3_reg [3];
    axis_t              eye3_reg [3];
    axis_t              z3_reg [3];
    logic               zok3_reg, v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cp2_reg[0] <= up1[1] * z1[2];
        cp2_reg[1] <= up1[2] * z1[1];
        cp2_reg[2] <= up1[2] * z1[0];
        cp2_reg[3] <= up1[0] * z1[2];
        cp2_reg[4] <= up1[0] * z1[1];
        cp2_reg[5] <= up1[1] * z1[0];
        eye2_reg   <= eye1;
        z2_reg     <= z1;
        zok2_reg   <= zok1;

        c3_reg[0]  <= cp2_reg[0] - cp2_reg[1];
        c3_reg[1]  <= cp2_reg[2] - cp2_reg[3];
        c3_reg[2]  <= cp2_reg[4] - cp2_reg[5];
        eye3_reg   <= eye2_reg;
        z3_reg     <= z2_reg;
        zok3_reg   <= zok2_reg;
    end

    // ------------------------------------------------------------------
    // X axis: normalize up cross z. Eye, z and the z flag ride along.
    // ------------------------------------------------------------------
    logic [SIDE2_W-1:0] side2_in, side2_out;
    axis_t              x4 [3];
    logic               xok4, v4;
    axis_t              eye4 [3];
    axis_t              z4 [3];
    logic               zok4;

    assign side2_in = {eye3_reg[0], eye3_reg[1], eye3_reg[2],
                       z3_reg[0], z3_reg[1], z3_reg[2], zok3_reg};

    lav_unit3 #(.W(64), .SW(SIDE2_W)) u_norm_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_vec    (c3_reg),
        .in_side   (side2_in),
        .out_valid (v4),
        .out_ok    (xok4),
        .out_q     (x4),
        .out_side  (side2_out)
    );

    assign eye4[0] = side2_out[192:161];
    assign eye4[1] = side2_out[160:129];
    assign eye4[2] = side2_out[128:97];
    assign z4[0]   = side2_out[96:65];
    assign z4[1]   = side2_out[64:33];
    assign z4[2]   = side2_out[32:1];
    assign zok4    = side2_out[0];

    // ------------------------------------------------------------------
    // Stages 5 and 6: y = z cross x, rounded back to Q2.30 and clamped.
    // ------------------------------------------------------------------
    logic signed [63:0] yp5_reg [6];
    axis_t              x5_reg [3];
    axis_t              z5_reg [3];
    axis_t              eye5_reg [3];
    logic               ok5_reg, v5_reg;
    axis_t              ax6_reg [3][3];
    axis_t              eye6_reg [3];
    logic               ok6_reg, v6_reg;
    logic signed [65:0] yr [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            yr[i] = rnd_q30(66'(yp5_reg[2*i]) - 66'(yp5_reg[2*i+1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        yp5_reg[0] <= z4[1] * x4[2];
        yp5_reg[1] <= z4[2] * x4[1];
        yp5_reg[2] <= z4[2] * x4[0];
        yp5_reg[3] <= z4[0] * x4[2];
        yp5_reg[4] <= z4[0] * x4[1];
        yp5_reg[5] <= z4[1] * x4[0];
        x5_reg     <= x4;
        z5_reg     <= z4;
        eye5_reg   <= eye4;
        ok5_reg    <= zok4 && xok4;

        for (int i = 0; i < 3; i++)
        begin
            if (yr[i] > POS_Q30)
            begin
                ax6_reg[1][i] <= POS_Q30[31:0];
            end
            else if (yr[i] < NEG_Q30)
            begin
                ax6_reg[1][i] <= NEG_Q30[31:0];
            end
            else
            begin
                ax6_reg[1][i] <= yr[i][31:0];
            end
        end
        ax6_reg[0] <= x5_reg;
        ax6_reg[2] <= z5_reg;
        eye6_reg   <= eye5_reg;
        ok6_reg    <= ok5_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: the nine axis times eye products for the translations.
    // ------------------------------------------------------------------
    logic signed [63:0] tp7_reg [3][3];
    axis_t              ax7_reg [3][3];
    logic               ok7_reg, v7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tp7_reg[r][i] <= ax6_reg[r][i] * eye6_reg[i];
            end
        end
        ax7_reg <= ax6_reg;
        ok7_reg <= ok6_reg;
    end

    // ------------------------------------------------------------------
    // Stage 8: negated dot product, rounded and saturated, into the row
    // holding registers. A degenerate camera zeroes the three axis rows.
    // ------------------------------------------------------------------
    logic signed [65:0] tr [3];
    logic signed [31:0] tsat [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tr[r] = rnd_q30(-(66'(tp7_reg[r][0]) + 66'(tp7_reg[r][1])
                              + 66'(tp7_reg[r][2])));
            if (tr[r] > POS_SAT)
            begin
                tsat[r] = POS_SAT[31:0];
            end
            else if (tr[r] < NEG_SAT)
            begin
                tsat[r] = NEG_SAT[31:0];
            end
            else
            begin
                tsat[r] = tr[r][31:0];
            end
        end
    end

    axis_t              hold_ax_reg [3][3];
    logic signed [31:0] hold_t_reg [3];
    logic               hold_ok_reg;
    logic [1:0]         emit_cnt_reg;
    logic               emit_act_reg;

    logic               row_valid_reg;
    logic [1:0]         row_index_reg;
    logic signed [31:0] col_a_reg, col_b_reg, col_c_reg, translation_reg;
    logic               last_row_reg, degenerate_reg;

    always_ff @(posedge clk)
    begin
        if (v7_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    hold_ax_reg[r][i] <= ok7_reg ? ax7_reg[r][i] : '0;
                end
                hold_t_reg[r] <= ok7_reg ? tsat[r] : '0;
            end
            hold_ok_reg <= ok7_reg;
        end
    end

    // Row sequencer: four consecutive strobes per camera. A new camera can
    // load on the same edge that sends the constant row of the previous one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_act_reg  <= 1'b0;
            emit_cnt_reg  <= ROW_X;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= emit_act_reg;
            if (v7_reg)
            begin
                emit_act_reg <= 1'b1;
                emit_cnt_reg <= ROW_X;
            end
            else if (emit_act_reg)
            begin
                emit_cnt_reg <= emit_cnt_reg + 2'd1;
                if (emit_cnt_reg == ROW_W)
                begin
                    emit_act_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_act_reg)
        begin
            row_index_reg  <= emit_cnt_reg;
            degenerate_reg <= !hold_ok_reg;
            last_row_reg   <= emit_cnt_reg == ROW_W;
            unique case (emit_cnt_reg) inside
                ROW_X, ROW_Y, ROW_Z:
                begin
                    col_a_reg       <= hold_ax_reg[emit_cnt_reg][0];
                    col_b_reg       <= hold_ax_reg[emit_cnt_reg][1];
                    col_c_reg       <= hold_ax_reg[emit_cnt_reg][2];
                    translation_reg <= hold_t_reg[emit_cnt_reg];
                end
                default:
                begin
                    col_a_reg       <= '0;
                    col_b_reg       <= '0;
                    col_c_reg       <= '0;
                    translation_reg <= ONE_Q16;
                end
            endcase
        end
    end

    assign row_valid   = row_valid_reg;
    assign row_index   = row_index_reg;
    assign col_a       = col_a_reg;
    assign col_b       = col_b_reg;
    assign col_c       = col_c_reg;
    assign translation = translation_reg;
    assign last_row    = last_row_reg;
    assign degenerate  = degenerate_reg;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the look-at view matrix builder. Camera
// transactions go in through start/busy, and each one predicts four matrix
// rows. Every strobed row is checked against the oldest predicted row.
// ----------------------------------------------------------------------------
module tb;

    import lav_pkg::*;

    // One predicted matrix row, laid out like the row output ports.
    typedef struct {
        logic [1:0]         index;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] trans;
        logic               last;
        logic               degen;
    } matrix_row_t;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam longint HALF_Q30 = 64'sd1 << 29;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] eye_x = '0;
    logic signed [31:0] eye_y = '0;
    logic signed [31:0] eye_z = '0;
    logic signed [31:0] target_x = '0;
    logic signed [31:0] target_y = '0;
    logic signed [31:0] target_z = '0;
    logic signed [31:0] up_x = '0;
    logic signed [31:0] up_y = '0;
    logic signed [31:0] up_z = '0;
    logic               row_valid;
    logic [1:0]         row_index;
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic signed [31:0] translation;
    logic               last_row;
    logic               degenerate;

    // Rows still owed by the block, oldest first.
    matrix_row_t pending_rows[$];
    int          mismatch_count = 0;
    int          cameras_sent = 0;
    int          degenerate_sent = 0;
    int          rows_checked = 0;

    look_at_view_matrix uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .eye_x      (eye_x),
        .eye_y      (eye_y),
        .eye_z      (eye_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .up_x       (up_x),
        .up_y       (up_y),
        .up_z       (up_z),
        .row_valid  (row_valid),
        .row_index  (row_index),
        .col_a      (col_a),
        .col_b      (col_b),
        .col_c      (col_c),
        .translation(translation),
        .last_row   (last_row),
        .degenerate (degenerate)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor. All arithmetic is done in 64-bit integers, which holds every
    // intermediate product exactly for 32-bit inputs and Q2.30 axes.
    // ------------------------------------------------------------------------

    // Floor square root, bit by bit.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n -= root + probe;
                root = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Unit vector in Q2.30. The magnitudes are scaled together so that the
    // largest lands in [2^29, 2^30) before the length is taken. Returns 0
    // when the vector is zero.
    function automatic bit normalize_axis(input longint vec[3], output longint unit_vec[3]);
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sum_sq;
        longint unsigned len;
        bit              neg[3];
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = vec[i] < 0;
            mag[i] = neg[i] ? 64'd0 - longint'(vec[i]) : vec[i];
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            for (int i = 0; i < 3; i++)
                unit_vec[i] = 0;
            return 1'b0;
        end
        while (peak >= (64'd1 << 30))
        begin
            peak >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (peak < (64'd1 << 29))
        begin
            peak <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        sum_sq = 0;
        for (int i = 0; i < 3; i++)
            sum_sq += mag[i] * mag[i];
        len = floor_sqrt(sum_sq);
        for (int i = 0; i < 3; i++)
        begin
            longint scaled;
            scaled = longint'((mag[i] << 30) / len);
            unit_vec[i] = neg[i] ? -scaled : scaled;
        end
        return 1'b1;
    endfunction

    // a*b - c*d back in Q2.30, rounded half up and clamped to +-1.0.
    function automatic longint cross_term(longint a, longint b, longint c, longint d);
        longint r;
        r = (a * b - c * d + HALF_Q30) >>> 30;
        if (r > ONE_Q30)
            r = ONE_Q30;
        if (r < -ONE_Q30)
            r = -ONE_Q30;
        return r;
    endfunction

    // -(axis . eye) in Q16.16, rounded half up and saturated.
    function automatic logic signed [31:0] axis_offset(input longint axis[3],
                                                      input longint eye[3]);
        longint s;
        longint t;
        s = axis[0] * eye[0] + axis[1] * eye[1] + axis[2] * eye[2];
        t = (-s + HALF_Q30) >>> 30;
        if (t > 64'sd2147483647)
            t = 64'sd2147483647;
        if (t < -64'sd2147483648)
            t = -64'sd2147483648;
        return t[31:0];
    endfunction

    // Builds the four rows of one camera and queues them.
    task automatic predict_view_rows(input logic signed [31:0] ex, ey, ez,
                                     input logic signed [31:0] tx, ty, tz,
                                     input logic signed [31:0] ux, uy, uz);
        longint      eye[3];
        longint      up[3];
        longint      dir[3];
        longint      side[3];
        longint      zax[3];
        longint      xax[3];
        longint      yax[3];
        longint      axes[3][3];
        bit          ok;
        matrix_row_t row;
        eye = '{ex, ey, ez};
        up  = '{ux, uy, uz};
        dir = '{longint'(ex) - tx, longint'(ey) - ty, longint'(ez) - tz};
        ok = normalize_axis(dir, zax);
        if (ok)
        begin
            side[0] = up[1] * zax[2] - up[2] * zax[1];
            side[1] = up[2] * zax[0] - up[0] * zax[2];
            side[2] = up[0] * zax[1] - up[1] * zax[0];
            ok = normalize_axis(side, xax);
        end
        if (ok)
        begin
            yax[0] = cross_term(zax[1], xax[2], zax[2], xax[1]);
            yax[1] = cross_term(zax[2], xax[0], zax[0], xax[2]);
            yax[2] = cross_term(zax[0], xax[1], zax[1], xax[0]);
        end
        axes[0] = xax;
        axes[1] = yax;
        axes[2] = zax;
        for (int r = 0; r < 3; r++)
        begin
            row.index = r[1:0];
            row.a     = ok ? axes[r][0][31:0] : '0;
            row.b     = ok ? axes[r][1][31:0] : '0;
            row.c     = ok ? axes[r][2][31:0] : '0;
            row.trans = ok ? axis_offset(axes[r], eye) : '0;
            row.last  = 1'b0;
            row.degen = !ok;
            pending_rows.push_back(row);
        end
        row.index = 2'd3;
        row.a     = '0;
        row.b     = '0;
        row.c     = '0;
        row.trans = ONE_Q16;
        row.last  = 1'b1;
        row.degen = !ok;
        pending_rows.push_back(row);
        if (!ok)
            degenerate_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------

    // Mostly back to back or short gaps, now and then a long one.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Sends one camera transaction and queues its rows once accepted.
    // Start is lowered only when a gap follows, so back to back transactions
    // keep it high across the accept edge.
    task automatic send_camera(input logic signed [31:0] ex, ey, ez,
                               input logic signed [31:0] tx, ty, tz,
                               input logic signed [31:0] ux, uy, uz);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        eye_x    <= ex;
        eye_y    <= ey;
        eye_z    <= ez;
        target_x <= tx;
        target_y <= ty;
        target_z <= tz;
        up_x     <= ux;
        up_y     <= uy;
        up_z     <= uz;
        do
            @(posedge clk);
        while (busy);
        predict_view_rows(ex, ey, ez, tx, ty, tz, ux, uy, uz);
        cameras_sent++;
    endtask

    // Coordinate with a random magnitude: full range down to a few LSBs.
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    localparam logic signed [31:0] Q16_ONE = 32'sd65536;
    localparam logic signed [31:0] S_MAX   = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN   = 32'sh80000000;

    // Plain cameras and the corners of the coordinate range.
    task automatic test_directed_cameras();
        send_camera(0, 0, 5 * Q16_ONE, 0, 0, 0, 0, Q16_ONE, 0);
        send_camera(Q16_ONE, 2 * Q16_ONE, 3 * Q16_ONE, -Q16_ONE, 0, 7, 0, 0, Q16_ONE);
        send_camera(10 * Q16_ONE, 0, 0, 0, 0, 0, 0, -Q16_ONE, 0);
        send_camera(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, 1);
        send_camera(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX);
        send_camera(S_MAX, 0, 0, S_MAX - 1, 0, 0, 0, S_MAX, 0);
        send_camera(1, 0, 0, 0, 0, 0, 0, 0, 1);
        send_camera(-1, -1, -1, 0, 0, 0, 1, 0, 0);
        send_camera(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa,
                    32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
                    32'sh33333333, 32'shcccccccc, 32'sh7f00ff00);
        // Translation saturation: the eye far out along each axis.
        send_camera(S_MAX, S_MAX, S_MAX, S_MAX - 2, S_MAX - 3, S_MAX - 1, 0, Q16_ONE, 0);
        send_camera(S_MIN, S_MIN, S_MIN, S_MIN + 5, S_MIN + 1, S_MIN + 2, Q16_ONE, 0, 0);
    endtask

    // Eye on the target, zero up vector, and up along the view direction.
    task automatic test_degenerate_cameras();
        send_camera(3 * Q16_ONE, -4, 5, 3 * Q16_ONE, -4, 5, 0, Q16_ONE, 0);
        send_camera(S_MIN, S_MAX, 0, S_MIN, S_MAX, 0, 1, 1, 1);
        send_camera(0, 0, 5 * Q16_ONE, 0, 0, 0, 0, 0, 0);
        send_camera(0, 0, 5 * Q16_ONE, 0, 0, 0, 0, 0, Q16_ONE);
        send_camera(0, 0, 5 * Q16_ONE, 0, 0, 0, 0, 0, -3 * Q16_ONE);
        send_camera(Q16_ONE, Q16_ONE, Q16_ONE, 0, 0, 0, 4, 4, 4);
        send_camera(0, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // Random cameras: mostly well-formed scenes of random scale, with some
    // degenerate setups and raw bit noise mixed in.
    task automatic test_random_cameras(input int count);
        logic signed [31:0] e[3];
        logic signed [31:0] t[3];
        logic signed [31:0] u[3];
        int                 kind;
        int                 k;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            for (int i = 0; i < 3; i++)
            begin
                e[i] = rand_coord();
                t[i] = rand_coord();
                u[i] = rand_coord();
            end
            if (kind < 20)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e[i] = $urandom;
                    t[i] = $urandom;
                    u[i] = $urandom;
                end
            end
            else if (kind < 27)
            begin
                t = e;
            end
            else if (kind < 34)
            begin
                // Up along eye - target, small enough that it does not wrap.
                k = $urandom_range(1, 3);
                for (int i = 0; i < 3; i++)
                begin
                    e[i] = $signed($urandom_range(0, 20000)) - 10000;
                    t[i] = $signed($urandom_range(0, 20000)) - 10000;
                    u[i] = (e[i] - t[i]) * k;
                end
            end
            else if (kind < 37)
            begin
                u = '{0, 0, 0};
            end
            send_camera(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking. Outputs are sampled at the edge that ends the strobe cycle.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && row_valid)
        begin
            if (pending_rows.size() == 0)
            begin
                report_mismatch("row with no camera outstanding");
            end
            else
            begin
                matrix_row_t want;
                want = pending_rows.pop_front();
                rows_checked++;
                if (row_index !== want.index)
                    report_mismatch($sformatf("row_index %0d want %0d", row_index, want.index));
                if (col_a !== want.a)
                    report_mismatch($sformatf("row %0d col_a %0d want %0d",
                                              want.index, col_a, want.a));
                if (col_b !== want.b)
                    report_mismatch($sformatf("row %0d col_b %0d want %0d",
                                              want.index, col_b, want.b));
                if (col_c !== want.c)
                    report_mismatch($sformatf("row %0d col_c %0d want %0d",
                                              want.index, col_c, want.c));
                if (translation !== want.trans)
                    report_mismatch($sformatf("row %0d translation %0d want %0d",
                                              want.index, translation, want.trans));
                if (last_row !== want.last)
                    report_mismatch($sformatf("row %0d last_row %b want %b",
                                              want.index, last_row, want.last));
                if (degenerate !== want.degen)
                    report_mismatch($sformatf("row %0d degenerate %b want %b",
                                              want.index, degenerate, want.degen));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of tests and the end of the run.
    // ------------------------------------------------------------------------

    initial
    begin
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cameras();
        test_degenerate_cameras();
        test_random_cameras(280);
        start <= 1'b0;

        // The pipeline is a few hundred stages at most; drain with a bound.
        waited = 0;
        while (pending_rows.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_rows.size() != 0)
            report_mismatch($sformatf("%0d rows never arrived", pending_rows.size()));
        repeat (300) @(posedge clk);

        $display("Covered %0d cameras (%0d degenerate), %0d rows checked, %0d mismatches.",
                 cameras_sent, degenerate_sent, rows_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog well past the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d rows outstanding.", pending_rows.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/lav_pkg.sv
rtl/lav_unit3.sv
rtl/look_at_view_matrix.sv
sim/tb.sv
